FILE: sv/limb_long_divider_core_macros.svh
// Assertion macros used by the checker file.
`ifndef LIMB_LONG_DIVIDER_CORE_MACROS_SVH
`define LIMB_LONG_DIVIDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off during reset.
`define LDC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: sv/ldc_pkg.sv
package ldc_pkg;

  localparam int LIMB_BITS      = 30;
  localparam int DIVIDEND_LIMBS = 4;
  localparam int DIVISOR_LIMBS  = 3;

  localparam int NUM_BITS = LIMB_BITS * DIVIDEND_LIMBS;
  localparam int DEN_BITS = LIMB_BITS * DIVISOR_LIMBS;
  // partial remainder stays below twice the divisor
  localparam int REM_BITS = DEN_BITS + 1;
  localparam int CNT_W    = $clog2(NUM_BITS);
  localparam int QSIZE_W  = 3;
  localparam int RSIZE_W  = 2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ldc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic den_zero;
  } ldc_sts_t;

endpackage

FILE: sv/ldc_ctrl.sv
module ldc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ldc_pkg::ldc_sts_t sts,
  output ldc_pkg::ldc_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [ldc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // sequence load, one step per quotient bit (none on a zero divisor), then finish
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = ldc_pkg::CNT_W'(ldc_pkg::NUM_BITS - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.den_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      ST_DONE: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/ldc_dp.sv
module ldc_dp (
  input  logic                             clk,
  input  ldc_pkg::ldc_cmd_t                cmd,
  output ldc_pkg::ldc_sts_t                sts,
  input  logic [ldc_pkg::NUM_BITS-1:0]     num_in,
  input  logic [ldc_pkg::DEN_BITS-1:0]     den_in,
  output logic [ldc_pkg::NUM_BITS-1:0]     quo_out,
  output logic [ldc_pkg::DEN_BITS-1:0]     rem_out,
  output logic [ldc_pkg::QSIZE_W-1:0]      qsize_out,
  output logic [ldc_pkg::RSIZE_W-1:0]      rsize_out,
  output logic                             dbz_out
);

  // num_r shifts dividend bits out at the top and quotient bits in at the bottom
  logic [ldc_pkg::NUM_BITS-1:0] num_r;
  logic [ldc_pkg::DEN_BITS-1:0] den_r;
  logic [ldc_pkg::REM_BITS-1:0] rem_r;
  logic                         dz_r;

  logic [ldc_pkg::NUM_BITS-1:0] quo_r;
  logic [ldc_pkg::DEN_BITS-1:0] remo_r;
  logic [ldc_pkg::QSIZE_W-1:0]  qsize_r;
  logic [ldc_pkg::RSIZE_W-1:0]  rsize_r;
  logic                         dbz_r;

  logic [ldc_pkg::REM_BITS-1:0] shifted;
  logic [ldc_pkg::REM_BITS:0]   diff;
  logic                         fits;
  logic [ldc_pkg::NUM_BITS-1:0] quo_fin;
  logic [ldc_pkg::DEN_BITS-1:0] rem_fin;
  logic [ldc_pkg::QSIZE_W-1:0]  qsize_fin;
  logic [ldc_pkg::RSIZE_W-1:0]  rsize_fin;

  assign sts.den_zero = dz_r;

  // shift in the next dividend bit, trial subtract the divisor
  always_comb begin
    shifted = {rem_r[ldc_pkg::REM_BITS-2:0], num_r[ldc_pkg::NUM_BITS-1]};
    diff    = {1'b0, shifted}
            - {{(ldc_pkg::REM_BITS + 1 - ldc_pkg::DEN_BITS){1'b0}}, den_r};
    fits    = ~diff[ldc_pkg::REM_BITS];
  end

  // zero results on a zero divisor, count significant limbs
  always_comb begin
    quo_fin   = dz_r ? '0 : num_r;
    rem_fin   = dz_r ? '0 : rem_r[ldc_pkg::DEN_BITS-1:0];
    qsize_fin = ldc_pkg::QSIZE_W'(1);
    for (int i = 1; i < ldc_pkg::DIVIDEND_LIMBS; i++) begin
      if (quo_fin[i*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS] != '0) begin
        qsize_fin = ldc_pkg::QSIZE_W'(i + 1);
      end
    end
    rsize_fin = ldc_pkg::RSIZE_W'(1);
    for (int i = 1; i < ldc_pkg::DIVISOR_LIMBS; i++) begin
      if (rem_fin[i*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS] != '0) begin
        rsize_fin = ldc_pkg::RSIZE_W'(i + 1);
      end
    end
  end

  // load operands, advance one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= num_in;
      den_r <= den_in;
      rem_r <= '0;
      dz_r  <= (den_in == '0);
    end else if (cmd.step) begin
      num_r <= {num_r[ldc_pkg::NUM_BITS-2:0], fits};
      rem_r <= fits ? diff[ldc_pkg::REM_BITS-1:0] : shifted;
    end
  end

  // capture the result for the output strobe
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      quo_r   <= quo_fin;
      remo_r  <= rem_fin;
      qsize_r <= qsize_fin;
      rsize_r <= rsize_fin;
      dbz_r   <= dz_r;
    end
  end

  assign quo_out   = quo_r;
  assign rem_out   = remo_r;
  assign qsize_out = qsize_r;
  assign rsize_out = rsize_r;
  assign dbz_out   = dbz_r;

endmodule

FILE: sv/limb_long_divider_core.sv
// A zero divisor skips the quotient-bit loop and goes straight to finish.
// One division runs at a time; start is taken in the strobe cycle.
// The restoring loop retires one quotient bit per cycle over the 120-bit dividend.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_valid.
// The receiver cannot stall: each result shows for exactly one cycle.
module limb_long_divider_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_dividend_limb0,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_dividend_limb1,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_dividend_limb2,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_dividend_limb3,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_divisor_limb0,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_divisor_limb1,
  input  logic [ldc_pkg::LIMB_BITS-1:0] in_divisor_limb2,
  output logic                          out_valid,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_quotient_limb0,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_quotient_limb1,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_quotient_limb2,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_quotient_limb3,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_remainder_limb0,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_remainder_limb1,
  output logic [ldc_pkg::LIMB_BITS-1:0] out_remainder_limb2,
  output logic [ldc_pkg::QSIZE_W-1:0]   out_quotient_size,
  output logic [ldc_pkg::RSIZE_W-1:0]   out_remainder_size,
  output logic                          out_divide_by_zero
);

  ldc_pkg::ldc_cmd_t            cmd;
  ldc_pkg::ldc_sts_t            sts;
  logic [ldc_pkg::NUM_BITS-1:0] num_in;
  logic [ldc_pkg::DEN_BITS-1:0] den_in;
  logic [ldc_pkg::NUM_BITS-1:0] quo;
  logic [ldc_pkg::DEN_BITS-1:0] rem;

  // gather limbs into flat operands
  assign num_in = {in_dividend_limb3, in_dividend_limb2, in_dividend_limb1, in_dividend_limb0};
  assign den_in = {in_divisor_limb2, in_divisor_limb1, in_divisor_limb0};

  ldc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ldc_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .num_in    (num_in),
    .den_in    (den_in),
    .quo_out   (quo),
    .rem_out   (rem),
    .qsize_out (out_quotient_size),
    .rsize_out (out_remainder_size),
    .dbz_out   (out_divide_by_zero)
  );

  // split results into limbs
  assign out_quotient_limb0  = quo[0*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_quotient_limb1  = quo[1*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_quotient_limb2  = quo[2*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_quotient_limb3  = quo[3*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_remainder_limb0 = rem[0*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_remainder_limb1 = rem[1*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];
  assign out_remainder_limb2 = rem[2*ldc_pkg::LIMB_BITS +: ldc_pkg::LIMB_BITS];

endmodule

FILE: sv/ldc_checker.sv
`include "limb_long_divider_core_macros.svh"

module ldc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [ldc_pkg::LIMB_BITS-1:0] out_quotient_limb0,
  input logic [ldc_pkg::LIMB_BITS-1:0] out_remainder_limb0,
  input logic [ldc_pkg::QSIZE_W-1:0]   out_quotient_size,
  input logic [ldc_pkg::RSIZE_W-1:0]   out_remainder_size,
  input logic                          out_divide_by_zero
);

  logic dbz_clean;

  // zero low limbs and unit sizes, as a zero divisor leaves them
  assign dbz_clean = (out_quotient_size == 3'd1) && (out_remainder_size == 2'd1)
                   && (out_quotient_limb0 == '0) && (out_remainder_limb0 == '0);

  // a transfer in makes the block busy
  `LDC_ASSERT_NXT(a_start_busy, start && !busy, busy)
  // the strobe lasts one cycle
  `LDC_ASSERT_NXT(a_strobe_pulse, out_valid, !out_valid)
  // a result only shows once the work is over
  `LDC_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  // zero divisor gives zero low limbs with unit sizes
  `LDC_ASSERT_NOW(a_dbz_zero, out_valid && out_divide_by_zero, dbz_clean)

endmodule

bind limb_long_divider_core ldc_checker u_ldc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_quotient_limb0  (out_quotient_limb0),
  .out_remainder_limb0 (out_remainder_limb0),
  .out_quotient_size   (out_quotient_size),
  .out_remainder_size  (out_remainder_size),
  .out_divide_by_zero  (out_divide_by_zero)
);
